// File: rtl/akg_pkg.sv
// Package: payload structs and NAL header constants for the Annex B keyframe gate.
package akg_pkg;

  localparam logic       REQ_BYTE  = 1'b0;
  localparam logic       REQ_FLUSH = 1'b1;

  localparam logic [7:0] START_BYTE = 8'h01;

  localparam logic [5:0] HEVC_TYPE_MASK = 6'h3F;
  localparam logic [5:0] HEVC_VPS       = 6'd32;
  localparam logic [5:0] HEVC_SPS       = 6'd33;
  localparam logic [5:0] HEVC_PPS       = 6'd34;
  localparam logic [5:0] HEVC_IDR_W     = 6'd19;
  localparam logic [5:0] HEVC_IDR_N     = 6'd20;

  localparam logic [4:0] AVC_TYPE_MASK = 5'h1F;
  localparam logic [4:0] AVC_SPS       = 5'd7;
  localparam logic [4:0] AVC_PPS       = 5'd8;
  localparam logic [4:0] AVC_IDR       = 5'd5;

  localparam logic [1:0] ZERO_RUN_MAX = 2'd3;

  typedef struct packed {
    logic       req_type;
    logic [7:0] data_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic idr_in_packet;
    logic vps_seen;
    logic sps_seen;
    logic pps_seen;
    logic params_complete;
    logic waiting_keyframe;
    logic keyframe_resumed;
  } out_t;

endpackage

// File: rtl/akg_scanner.sv
// Start code scanner, NAL type decode and keyframe gate state.
module akg_scanner (
  input  logic          clk,
  input  logic          rst,
  input  logic          step,
  input  akg_pkg::in_t  item,
  input  logic          hevc_mode,
  output logic          res_valid,
  output akg_pkg::out_t res
);

  logic [1:0] zero_run, zero_run_next;
  logic       header_next, header_next_next;
  logic       long_code, long_code_next;
  logic       packet_idr, packet_idr_next;
  logic       have_vps, have_vps_next;
  logic       have_sps, have_sps_next;
  logic       have_pps, have_pps_next;
  logic       wait_flag, wait_flag_next;

  logic       flush;
  logic       hdr_read;
  logic [5:0] hevc_type;
  logic [4:0] avc_type;
  logic       params;
  logic       resumed;

  assign flush     = (item.req_type == akg_pkg::REQ_FLUSH);
  assign hevc_type = item.data_byte[6:1] & akg_pkg::HEVC_TYPE_MASK;
  assign avc_type  = item.data_byte[4:0] & akg_pkg::AVC_TYPE_MASK;
  // header after a short code on the packet's last byte is dropped
  assign hdr_read  = header_next && !(item.last_byte && !long_code);

  always_comb begin
    zero_run_next    = zero_run;
    header_next_next = header_next;
    long_code_next   = long_code;
    packet_idr_next  = packet_idr;
    have_vps_next    = have_vps;
    have_sps_next    = have_sps;
    have_pps_next    = have_pps;
    wait_flag_next   = wait_flag;
    params           = 1'b0;
    resumed          = 1'b0;
    res_valid        = 1'b0;

    if (flush) begin
      wait_flag_next = 1'b1;
    end else begin
      if (hdr_read) begin
        if (hevc_mode) begin
          if (hevc_type == akg_pkg::HEVC_VPS) begin
            have_vps_next = 1'b1;
          end else if (hevc_type == akg_pkg::HEVC_SPS) begin
            have_sps_next = 1'b1;
          end else if (hevc_type == akg_pkg::HEVC_PPS) begin
            have_pps_next = 1'b1;
          end else if (hevc_type == akg_pkg::HEVC_IDR_W ||
                       hevc_type == akg_pkg::HEVC_IDR_N) begin
            packet_idr_next = 1'b1;
          end
        end else begin
          if (avc_type == akg_pkg::AVC_SPS) begin
            have_sps_next = 1'b1;
          end else if (avc_type == akg_pkg::AVC_PPS) begin
            have_pps_next = 1'b1;
          end else if (avc_type == akg_pkg::AVC_IDR) begin
            packet_idr_next = 1'b1;
          end
        end
      end
      header_next_next = 1'b0;
      long_code_next   = 1'b0;

      if (item.data_byte == 8'h00) begin
        if (zero_run != akg_pkg::ZERO_RUN_MAX) begin
          zero_run_next = zero_run + 2'd1;
        end
      end else begin
        if (item.data_byte == akg_pkg::START_BYTE && zero_run[1]) begin
          header_next_next = 1'b1;
          long_code_next   = (zero_run == akg_pkg::ZERO_RUN_MAX);
        end
        zero_run_next = 2'd0;
      end

      if (item.last_byte) begin
        params    = have_sps_next && have_pps_next && (!hevc_mode || have_vps_next);
        resumed   = wait_flag && params && packet_idr_next;
        res_valid = 1'b1;
        if (resumed) begin
          wait_flag_next = 1'b0;
        end
      end
    end
  end

  always_comb begin
    res.idr_in_packet    = packet_idr_next;
    res.vps_seen         = have_vps_next;
    res.sps_seen         = have_sps_next;
    res.pps_seen         = have_pps_next;
    res.params_complete  = params;
    res.waiting_keyframe = wait_flag_next;
    res.keyframe_resumed = resumed;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      zero_run    <= 2'd0;
      header_next <= 1'b0;
      long_code   <= 1'b0;
      packet_idr  <= 1'b0;
      have_vps    <= 1'b0;
      have_sps    <= 1'b0;
      have_pps    <= 1'b0;
      wait_flag   <= 1'b1;
    end else if (step) begin
      have_vps  <= have_vps_next;
      have_sps  <= have_sps_next;
      have_pps  <= have_pps_next;
      wait_flag <= wait_flag_next;
      // packet end: no start code spans two packets
      if (res_valid) begin
        zero_run    <= 2'd0;
        header_next <= 1'b0;
        long_code   <= 1'b0;
        packet_idr  <= 1'b0;
      end else begin
        zero_run    <= zero_run_next;
        header_next <= header_next_next;
        long_code   <= long_code_next;
        packet_idr  <= packet_idr_next;
      end
    end
  end

`ifndef SYNTH
  a_pkt_end_clears: assert property (@(posedge clk) disable iff (rst)
    step && res_valid |=> zero_run == 2'd0 && !header_next && !packet_idr)
    else $error("scan state not cleared at packet end");

  a_sps_sticky: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $past(have_sps) |-> have_sps)
    else $error("parameter set mark dropped");

  a_resume_cause: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.keyframe_resumed |-> res.params_complete && res.idr_in_packet
      && wait_flag)
    else $error("resume without parameter sets and IDR");
`endif

endmodule

// File: rtl/annexb_nal_keyframe_gate.sv
// Top level: input register, scanner, result register and mode register.
//
//   channel | dir | handshake          | payload
//   in      | in  | in_valid/in_stall  | in_data  (akg_pkg::in_t)
//   out     | out | out_valid/out_stall| out_data (akg_pkg::out_t)
//   cfg     | in  | cfg_wen            | cfg_data (hevc_mode)
//
// One item per cycle while in_stall is low; a packet's result passes through the
// input register, then the result register, once its last byte is taken.
// Reset clears the scan state, the parameter set marks and hevc_mode, and
// sets the wait-for-keyframe flag.
// A stalled result holds the result register; bytes and flushes that give no
// result keep moving, a last byte waits in the input register.
module annexb_nal_keyframe_gate (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  akg_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output akg_pkg::out_t out_data,
  input  logic          cfg_wen,
  input  logic          cfg_data
);

  logic          hevc_mode;
  logic          s1_valid;
  akg_pkg::in_t  s1_data;
  logic          advance;
  logic          res_valid;
  akg_pkg::out_t res;

  // item with a result needs a free result register
  assign advance  = s1_valid && (!res_valid || !out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      hevc_mode <= 1'b0;
    end else if (cfg_wen) begin
      hevc_mode <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_data <= in_data;
    end
  end

  akg_scanner u_scanner (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .item      (s1_data),
    .hevc_mode (hevc_mode),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && res_valid) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_data <= res;
    end
  end

`ifndef SYNTH
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && out_valid && out_stall)
    else $error("input stalled without a held result");

  a_no_result: assert property (@(posedge clk) disable iff (rst)
    s1_valid && (s1_data.req_type == akg_pkg::REQ_FLUSH || !s1_data.last_byte)
      |=> out_valid == $past(out_valid && out_stall))
    else $error("result from an item that gives none");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    advance && res_valid |=> out_valid)
    else $error("packet end result lost");
`endif

endmodule

// File: tb/sv/annexb_nal_keyframe_gate_checker.sv
// Checker for the keyframe gate: NAL scan predictor and in-order result compare.
`timescale 1ns / 100ps

module annexb_nal_keyframe_gate_checker (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          in_stall,
  input  akg_pkg::in_t  in_data,
  input  logic          out_valid,
  input  logic          out_stall,
  input  akg_pkg::out_t out_data,
  input  logic          cfg_wen,
  input  logic          cfg_data,
  output int            fail_count,
  output int            results_owed
);

  akg_pkg::out_t packet_reports[$];
  int            fails;

  logic       hevc_sel;
  logic [1:0] zero_cnt;
  logic       hdr_due;
  logic       hdr_long;
  logic       idr_mark;
  logic       vps_mark;
  logic       sps_mark;
  logic       pps_mark;
  logic       gate_wait;

  task automatic scan_item(input akg_pkg::in_t item);
    logic [5:0]    hevc_type;
    logic [4:0]    avc_type;
    logic          params;
    akg_pkg::out_t rpt;
    hevc_type = item.data_byte[6:1] & akg_pkg::HEVC_TYPE_MASK;
    avc_type  = item.data_byte[4:0] & akg_pkg::AVC_TYPE_MASK;
    if (item.req_type == akg_pkg::REQ_FLUSH) begin
      // re-arm only; the packet scan is untouched
      gate_wait = 1'b1;
      return;
    end
    if (hdr_due) begin
      // header after a short code on the last byte is dropped
      if (!(item.last_byte && !hdr_long)) begin
        if (hevc_sel) begin
          if (hevc_type == akg_pkg::HEVC_VPS) vps_mark = 1'b1;
          else if (hevc_type == akg_pkg::HEVC_SPS) sps_mark = 1'b1;
          else if (hevc_type == akg_pkg::HEVC_PPS) pps_mark = 1'b1;
          else if (hevc_type == akg_pkg::HEVC_IDR_W ||
                   hevc_type == akg_pkg::HEVC_IDR_N) idr_mark = 1'b1;
        end else begin
          if (avc_type == akg_pkg::AVC_SPS) sps_mark = 1'b1;
          else if (avc_type == akg_pkg::AVC_PPS) pps_mark = 1'b1;
          else if (avc_type == akg_pkg::AVC_IDR) idr_mark = 1'b1;
        end
      end
      hdr_due  = 1'b0;
      hdr_long = 1'b0;
    end
    if (item.data_byte == 8'h00) begin
      if (zero_cnt != akg_pkg::ZERO_RUN_MAX) zero_cnt = zero_cnt + 2'd1;
    end else begin
      if (item.data_byte == akg_pkg::START_BYTE && zero_cnt >= 2'd2) begin
        hdr_due  = 1'b1;
        hdr_long = (zero_cnt == akg_pkg::ZERO_RUN_MAX);
      end
      zero_cnt = 2'd0;
    end
    if (!item.last_byte) return;
    params = sps_mark && pps_mark && (hevc_sel ? vps_mark : 1'b1);
    rpt.keyframe_resumed = gate_wait && params && idr_mark;
    if (rpt.keyframe_resumed) gate_wait = 1'b0;
    rpt.idr_in_packet    = idr_mark;
    rpt.vps_seen         = vps_mark;
    rpt.sps_seen         = sps_mark;
    rpt.pps_seen         = pps_mark;
    rpt.params_complete  = params;
    rpt.waiting_keyframe = gate_wait;
    packet_reports.push_back(rpt);
    zero_cnt = 2'd0;
    hdr_due  = 1'b0;
    hdr_long = 1'b0;
    idr_mark = 1'b0;
  endtask

  always @(posedge clk) begin : watch
    akg_pkg::out_t want;
    if (rst) begin
      packet_reports.delete();
      fails     = 0;
      hevc_sel  = 1'b0;
      zero_cnt  = 2'd0;
      hdr_due   = 1'b0;
      hdr_long  = 1'b0;
      idr_mark  = 1'b0;
      vps_mark  = 1'b0;
      sps_mark  = 1'b0;
      pps_mark  = 1'b0;
      gate_wait = 1'b1;
    end else begin
      if (out_valid && !out_stall) begin
        if (packet_reports.size() == 0) begin
          if (fails < 10) $display("%0t: unexpected result %b", $time, out_data);
          fails++;
        end else begin
          want = packet_reports.pop_front();
          if (out_data !== want) begin
            if (fails < 10)
              $display("%0t: result mismatch (idr vps sps pps params wait resumed) exp %b got %b",
                       $time, want, out_data);
            fails++;
          end
        end
      end
      if (in_valid && !in_stall) scan_item(in_data);
      if (cfg_wen) hevc_sel = cfg_data;
    end
    fail_count   <= fails;
    results_owed <= packet_reports.size();
  end

endmodule

// File: tb/sv/annexb_nal_keyframe_gate_tb.sv
// Testbench top for the keyframe gate: clock, reset, stimulus, mode phases, verdict.
`timescale 1ns / 100ps

module annexb_nal_keyframe_gate_tb;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int RANDOM_ITEMS  = 1060;
  localparam int PHASES        = 6;
  localparam int SETTLE_CYCLES = 8;

  logic          clk       = 1'b0;
  logic          rst       = 1'b1;
  logic          in_valid  = 1'b0;
  logic          in_stall;
  akg_pkg::in_t  in_data   = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  akg_pkg::out_t out_data;
  logic          cfg_wen   = 1'b0;
  logic          cfg_data  = 1'b0;

  int          fail_count;
  int          results_owed;
  int unsigned cycles    = 0;
  int unsigned hold_cnt  = 0;
  int          items_sent = 0;
  bit          sender_idles   = 1'b1;
  bit          receiver_stalls = 1'b1;
  logic [7:0]  pkt_q[$];

  annexb_nal_keyframe_gate u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_wen   (cfg_wen),
    .cfg_data  (cfg_data)
  );

  annexb_nal_keyframe_gate_checker u_check (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data),
    .cfg_wen      (cfg_wen),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .results_owed (results_owed)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // receiver holds off a random number of cycles after each result transaction while receiver_stalls is set
  always @(posedge clk) begin
    if (out_valid && !out_stall) hold_cnt <= receiver_stalls ? $urandom_range(0, 5) : 0;
    else if (hold_cnt != 0) hold_cnt <= hold_cnt - 1;
  end

  always @(negedge clk) out_stall <= (hold_cnt != 0);

  task automatic put_item(input logic req, input logic [7:0] b, input logic last);
    int gap;
    gap = sender_idles ? $urandom_range(0, 5) : 0;
    if (gap != 0) begin
      @(negedge clk) in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= '{req, b, last};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic load(input logic [127:0] bytes, input int n);
    for (int i = n - 1; i >= 0; i--) pkt_q.push_back(bytes[8*i +: 8]);
  endtask

  // sends pkt_q as one packet; a flush goes in ahead of byte flush_at
  task automatic drive_packet(input int flush_at);
    int last_idx;
    last_idx = pkt_q.size() - 1;
    for (int i = 0; i <= last_idx; i++) begin
      if (i == flush_at)
        put_item(akg_pkg::REQ_FLUSH, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      put_item(akg_pkg::REQ_BYTE, pkt_q[i], i == last_idx);
    end
    pkt_q.delete();
  endtask

  task automatic drain;
    @(negedge clk) in_valid <= 1'b0;
    while (results_owed != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_mode(input logic hevc);
    drain();
    cfg_wen  <= 1'b1;
    cfg_data <= hevc;
    @(negedge clk) cfg_wen <= 1'b0;
  endtask

  task automatic random_packet;
    int         nals;
    int         zeros;
    int         tail;
    logic [7:0] b;
    if ($urandom_range(0, 4) != 0) begin
      // well-formed: start codes, typed headers, short payloads
      nals = $urandom_range(1, 3);
      repeat (nals) begin
        zeros = ($urandom_range(0, 5) == 0) ? $urandom_range(4, 6) : $urandom_range(2, 3);
        repeat (zeros) pkt_q.push_back(8'h00);
        pkt_q.push_back(akg_pkg::START_BYTE);
        b = 8'($urandom_range(0, 255));
        case ($urandom_range(0, 9))
          0: b[6:1] = akg_pkg::HEVC_VPS;
          1: b[6:1] = akg_pkg::HEVC_SPS;
          2: b[6:1] = akg_pkg::HEVC_PPS;
          3: b[6:1] = $urandom_range(0, 1) ? akg_pkg::HEVC_IDR_W : akg_pkg::HEVC_IDR_N;
          4: b[4:0] = akg_pkg::AVC_SPS;
          5: b[4:0] = akg_pkg::AVC_PPS;
          6: b[4:0] = akg_pkg::AVC_IDR;
          default: ;
        endcase
        pkt_q.push_back(b);
        tail = $urandom_range(0, 4);
        repeat (tail)
          pkt_q.push_back(($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(0, 255)));
      end
    end else begin
      tail = $urandom_range(1, 10);
      repeat (tail) begin
        case ($urandom_range(0, 3))
          0, 1: pkt_q.push_back(8'h00);
          2: pkt_q.push_back(akg_pkg::START_BYTE);
          default: pkt_q.push_back(8'($urandom_range(0, 255)));
        endcase
      end
    end
    drive_packet(($urandom_range(0, 19) == 0) ? $urandom_range(0, pkt_q.size() - 1) : -1);
  endtask

  initial begin
    int target;
    repeat (3) @(negedge clk);
    rst <= 1'b0;

    // H.264: short code with header as last byte is dropped
    load(128'h00_00_01_67, 4);
    drive_packet(-1);
    // long code with header as last byte is read
    load(128'h00_00_00_01_67, 5);
    drive_packet(-1);
    // start code split across packets does not count
    load(128'h00_00, 2);
    drive_packet(-1);
    load(128'h01_68, 2);
    drive_packet(-1);
    // PPS then IDR, flush in the middle of the packet
    load(128'h00_00_01_68_00_00_00_01_65, 9);
    drive_packet(4);
    put_item(akg_pkg::REQ_FLUSH, 8'hFF, 1'b1);
    // mode switch in the middle of a packet, then VPS and IDR type 20
    repeat (3) put_item(akg_pkg::REQ_BYTE, 8'h00, 1'b0);
    put_item(akg_pkg::REQ_BYTE, akg_pkg::START_BYTE, 1'b0);
    set_mode(1'b1);
    load(128'h40_00_00_00_01_28, 6);
    drive_packet(-1);

    target = items_sent;
    for (int p = 0; p < PHASES; p++) begin
      set_mode(p % 2 == 0 ? 1'b0 : 1'b1);
      target += RANDOM_ITEMS / PHASES;
      while (items_sent < target) begin
        if ($urandom_range(0, 7) == 0) sender_idles = !sender_idles;
        if ($urandom_range(0, 7) == 0) receiver_stalls = !receiver_stalls;
        if ($urandom_range(0, 9) == 0)
          put_item(akg_pkg::REQ_FLUSH, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        random_packet();
      end
    end

    drain();
    if (fail_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
